### design/mwtg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table builder for the tone generator.
// No dependencies; every other design file imports this package.
package mwtg_pkg;

    localparam int PHASE_W     = 32;
    localparam int CNT_W       = 22;
    localparam int DUR_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int AMP_W       = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_SAMPLE_RATE      = 48000;
    localparam int DEF_SINE_TABLE_DEPTH = 256;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd39370534;
    localparam logic [CNT_W-1:0]   CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [AMP_W-1:0]   AMP_MAX          = 15'd32767;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Duration scaling: samples = (duration_ms * DUR_SCALE) >> DUR_SHIFT
    localparam int DUR_SHIFT   = 27;
    localparam int DUR_SCALE_W = 34;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM   = 2'd1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        wave_t              waveform;
    } cfg_t;

    // Quarter-wave sine amplitude from a Q2.30 angle, series in fixed point
    function automatic logic [AMP_W-1:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        v  = (s * 64'd32767) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[AMP_W-1:0];
    endfunction

endpackage

### design/mwtg_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result samples and configuration writes.
// Depends on mwtg_pkg.
interface mwtg_item_if import mwtg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [DUR_W-1:0] duration_ms;

    modport source (output valid, func, duration_ms, input ready);
    modport sink   (input valid, func, duration_ms, output ready);
endinterface

interface mwtg_result_if import mwtg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

interface mwtg_cfg_if import mwtg_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/mwtg_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: phase step and waveform select.
// Depends on mwtg_pkg and mwtg_cfg_if.
module mwtg_cfg_regs
    import mwtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mwtg_cfg_if.sink    cfg,
    output cfg_t        cfg_state
);

    logic [PHASE_W-1:0] phase_step_reg;
    wave_t              waveform_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            waveform_reg   <= WAVE_SINE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_PHASE_STEP: phase_step_reg <= cfg.data[PHASE_W-1:0];
                REG_WAVEFORM:   waveform_reg   <= wave_t'(cfg.data[1:0]);
                default:        ;
            endcase
        end
    end

    assign cfg_state.phase_step = phase_step_reg;
    assign cfg_state.waveform   = waveform_reg;

endmodule

### design/mwtg_wave.sv
`timescale 1ns / 1ps
// Waveform shaper: maps a 0.32 phase to a signed sample for the selected shape.
// Holds the quarter-wave sine table. Depends on mwtg_pkg.
module mwtg_wave
    import mwtg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
)
(
    input  logic [PHASE_W-1:0]         phase,
    input  wave_t                      waveform,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PRD_W = 30 + IDX_W;
    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(SINE_TABLE_DEPTH);

    logic [AMP_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        assign sine_rom[k] = sine_from_x(ANGLE);
    end

    logic [1:0]          quad;
    logic [29:0]         frac;
    logic [PRD_W-1:0]    idx_prod;
    logic [IDX_W-1:0]    idx;
    logic [31:0]         saw_d;
    logic [46:0]         saw_w;
    logic [30:0]         tri_m;
    logic [45:0]         tri_w;
    logic [SAMPLE_W-1:0] mag;
    logic                neg;

    assign quad     = phase[31:30];
    assign frac     = phase[29:0];
    assign idx_prod = PRD_W'(frac) * PRD_W'(DEPTH);
    assign idx      = quad[0] ? (DEPTH - idx_prod[PRD_W-1:30]) : idx_prod[PRD_W-1:30];

    assign saw_d = phase[31] ? {1'b0, phase[30:0]}
                             : (32'h8000_0000 - {1'b0, phase[30:0]});
    assign saw_w = {saw_d, 15'b0} - 47'(saw_d);

    assign tri_m = quad[0] ? (31'h4000_0000 - {1'b0, frac}) : {1'b0, frac};
    assign tri_w = {tri_m, 15'b0} - 46'(tri_m);

    always_comb
    begin
        case (waveform)
            WAVE_SINE:
            begin
                mag = {1'b0, sine_rom[idx]};
                neg = quad[1];
            end
            WAVE_SAW:
            begin
                mag = saw_w[46:31];
                neg = !phase[31];
            end
            WAVE_SQUARE:
            begin
                mag = {1'b0, AMP_MAX};
                neg = phase[31];
            end
            WAVE_TRIANGLE:
            begin
                mag = tri_w[45:30];
                neg = quad[1];
            end
            default:
            begin
                mag = '0;
                neg = 1'b0;
            end
        endcase
    end

    assign sample = neg ? $signed(~mag + 16'd1) : $signed(mag);

endmodule

### design/multi_waveform_tone_generator.sv
`timescale 1ns / 1ps
// Tone generator top level: input register, phase and sample counters, result register.
// Depends on mwtg_pkg, mwtg_if, mwtg_cfg_regs and mwtg_wave.
//
//  Port     Direction  Carries
//  cfg      sink       register index, write data
//  item     sink       func, duration_ms
//  result   source     sample, last
//
// One item per cycle unless result stalls; tick samples go to the result register.
// The throughput is set by the single shaper/counter pass between the two registers.
// Reset clears the valid flags, phase and sample counter; config returns to its defaults.
// A stalled result holds the pipeline; the input register still fills behind it.
module multi_waveform_tone_generator
    import mwtg_pkg::*;
#(
    parameter int SAMPLE_RATE      = DEF_SAMPLE_RATE,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    mwtg_cfg_if.sink      cfg,
    mwtg_item_if.sink     item,
    mwtg_result_if.source result
);

    localparam logic [63:0] DUR_SCALE_64 =
        ((64'(SAMPLE_RATE) << DUR_SHIFT) + 64'd999) / 64'd1000;
    localparam logic [DUR_SCALE_W-1:0] DUR_SCALE = DUR_SCALE_64[DUR_SCALE_W-1:0];
    localparam int DPRD_W = DUR_W + DUR_SCALE_W;

    cfg_t cfg_state;

    mwtg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    logic             s1_vld_reg;
    logic             s1_vld_next;
    logic             s1_func_reg;
    logic [DUR_W-1:0] s1_dur_reg;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic                       out_vld_reg;
    logic                       out_vld_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;

    logic                       s1_fire;
    logic                       produce;
    logic                       in_accept;
    logic [DPRD_W-1:0]          dur_prod;
    logic [CNT_W-1:0]           start_count;
    logic signed [SAMPLE_W-1:0] wave_sample;

    assign s1_fire    = s1_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !s1_vld_reg || s1_fire;
    assign in_accept  = item.valid && item.ready;
    assign produce    = (s1_func_reg == FUNC_TICK) && (count_reg != '0);

    assign dur_prod    = DPRD_W'(s1_dur_reg) * DPRD_W'(DUR_SCALE);
    assign start_count = (dur_prod[DPRD_W-1:DUR_SHIFT+CNT_W] != '0) ? CNT_MAX
                                : dur_prod[DUR_SHIFT+CNT_W-1:DUR_SHIFT];

    mwtg_wave #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .phase    (phase_reg),
        .waveform (cfg_state.waveform),
        .sample   (wave_sample)
    );

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (s1_fire)
        begin
            if (s1_func_reg == FUNC_START)
            begin
                phase_next = '0;
                count_next = start_count;
            end
            else if (produce)
            begin
                phase_next = phase_reg + cfg_state.phase_step;
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (s1_fire)
        begin
            out_vld_next = produce;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            phase_reg   <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg <= item.func;
            s1_dur_reg  <= item.duration_ms;
        end
        if (s1_fire && produce)
        begin
            sample_reg <= wave_sample;
            last_reg   <= (count_reg == CNT_W'(1));
        end
    end

    assign result.valid  = out_vld_reg;
    assign result.sample = sample_reg;
    assign result.last   = last_reg;

`ifndef SYNTHESIS
    a_start_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_func_reg == FUNC_START) |=> phase_reg == '0)
        else $error("phase not cleared after start");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_func_reg == FUNC_TICK) && (count_reg == '0)
        |=> $stable(phase_reg) && (count_reg == '0) && !out_vld_reg)
        else $error("idle tick changed state or produced a sample");

    a_last_ends_tone: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && produce && (count_reg == CNT_W'(1)) |=> (count_reg == '0) && result.last)
        else $error("final sample did not empty the counter");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(s1_fire))
        else $error("result appeared without a transaction from the input stage");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> s1_vld_reg && out_vld_reg && !result.ready)
        else $error("input stalled while pipeline could advance");
`endif

endmodule
